>>> rtl/core/lmq_pkg.sv
// Shared constants, types and codes of the linked-list multi-queue manager.
`timescale 1ns / 1ps
package lmq_pkg;

    localparam int NUM_QUEUES   = 4;
    localparam int NUM_CHANNELS = 64;

    localparam int QUEUE_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CHAN_W  = $clog2(NUM_CHANNELS);
    localparam int LINK_W  = CHAN_W + 1;
    localparam int STEP_W  = $clog2(NUM_CHANNELS + 1);

    typedef logic [1:0]         t_cmd_code;
    typedef logic [1:0]         t_status;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [QUEUE_W-1:0] t_queue;
    typedef logic [LINK_W-1:0]  t_link;
    typedef logic [STEP_W-1:0]  t_steps;

    localparam t_link NIL = t_link'(NUM_CHANNELS);

    localparam t_cmd_code CMD_ENQUEUE = 2'd0;
    localparam t_cmd_code CMD_REMOVE  = 2'd1;
    localparam t_cmd_code CMD_MOVE    = 2'd2;
    localparam t_cmd_code CMD_HEAD    = 2'd3;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NOT_QUEUED = 2'd1;
    localparam t_status ST_QUEUED     = 2'd2;

endpackage

>>> rtl/core/lmq_cmd_if.sv
// Command channel of the multi-queue manager: valid, ready and one command.
`timescale 1ns / 1ps
interface lmq_cmd_if;
    import lmq_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_code command;
    t_chan     channel;
    logic [1:0] queue;

    modport source (output valid, output command, output channel, output queue, input ready);
    modport sink   (input valid, input command, input channel, input queue, output ready);
endinterface

>>> rtl/core/lmq_rsp_if.sv
// Result channel of the multi-queue manager: valid, ready and one result.
`timescale 1ns / 1ps
interface lmq_rsp_if;
    import lmq_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    logic    head_valid;
    t_chan   head_channel;

    modport source (output valid, output status, output head_valid, output head_channel,
                    input ready);
    modport sink   (input valid, input status, input head_valid, input head_channel,
                    output ready);
endinterface

>>> rtl/core/lmq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module lmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/linked_multi_queue_manager_unit.sv
// Top level of the linked-list multi-queue manager with its command sequencer.
//
//   Port     Dir   Carries
//   i_cmd    in    command, channel, queue
//   o_rsp    out   status, head_valid, head_channel
//
// A command is taken only while the sequencer is idle; a finished result waits in
// the output register, so the next command may enter before it is taken.
// A head read, a failing command or a move into the channel's own queue goes
// straight to its result; an enqueue appends the channel, a remove walks the list
// and unlinks the channel, and a move walks, unlinks and appends. The list walk
// reads one link per cycle from the next-link memory.
// Reset empties every queue at once; the link and membership memories are not cleared.
// A result that is not taken stalls the sequencer in its final cycle.
`timescale 1ns / 1ps
module linked_multi_queue_manager_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lmq_cmd_if.sink   i_cmd,
    lmq_rsp_if.source o_rsp
);
    import lmq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MQ   = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_APP1 = 3'd4;
    localparam logic [2:0] S_APP2 = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]            r_state;
    logic [NUM_CHANNELS-1:0] r_queued;
    t_link                 r_head [NUM_QUEUES];
    t_link                 r_tail [NUM_QUEUES];

    t_cmd_code r_cmd;
    t_chan     r_ch;
    t_queue    r_q;
    t_queue    r_uq;
    t_link     r_cur;
    t_link     r_prev;
    logic      r_first;
    t_steps    r_steps;
    t_status   r_status;
    logic      r_show;

    logic    r_out_valid;
    t_status r_out_status;
    logic    r_out_hv;
    t_chan   r_out_hc;

    logic   nl_we;
    t_chan  nl_waddr;
    t_link  nl_wdata;
    t_chan  nl_raddr;
    t_link  nl_rdata;
    t_queue mq_rdata;

    logic  l_accept;
    t_link l_cur;
    logic  l_stop;
    t_link l_ch_link;
    t_link l_head;
    logic  l_hv;
    logic  l_out_load;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign l_accept    = i_cmd.valid && i_cmd.ready;
    assign l_ch_link   = {1'b0, r_ch};
    assign l_cur       = r_first ? r_cur : nl_rdata;
    assign l_stop      = (l_cur == l_ch_link) || (l_cur >= NIL) ||
                         (r_steps >= t_steps'(NUM_CHANNELS));
    assign l_head      = r_head[r_q];
    assign l_hv        = r_show && (l_head < NIL);
    assign l_out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        nl_we    = 1'b0;
        nl_waddr = r_ch;
        nl_wdata = NIL;
        nl_raddr = l_cur[CHAN_W-1:0];
        unique case (r_state)
            S_APP1: begin
                nl_we = 1'b1;
            end
            S_APP2: begin
                if (r_head[r_q] != NIL && r_tail[r_q] < NIL) begin
                    nl_we    = 1'b1;
                    nl_waddr = r_tail[r_q][CHAN_W-1:0];
                    nl_wdata = l_ch_link;
                end
            end
            S_FIX: begin
                if (r_cur == l_ch_link && r_prev != NIL) begin
                    nl_we    = 1'b1;
                    nl_waddr = r_prev[CHAN_W-1:0];
                    nl_wdata = nl_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    lmq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CHANNELS)) u_next_link (
        .i_clk   (i_clk),
        .i_we    (nl_we),
        .i_waddr (nl_waddr),
        .i_wdata (nl_wdata),
        .i_raddr (nl_raddr),
        .o_rdata (nl_rdata)
    );

    lmq_ram #(.WIDTH(QUEUE_W), .DEPTH(NUM_CHANNELS)) u_member_queue (
        .i_clk   (i_clk),
        .i_we    (r_state == S_APP1),
        .i_waddr (r_ch),
        .i_wdata (r_q),
        .i_raddr (i_cmd.channel),
        .o_rdata (mq_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_queued    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
        end else begin
            if (l_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (l_accept) begin
                        r_cmd    <= i_cmd.command;
                        r_ch     <= i_cmd.channel;
                        r_q      <= i_cmd.queue[QUEUE_W-1:0];
                        r_status <= ST_OK;
                        r_show   <= 1'b1;
                        r_state  <= S_MQ;
                    end
                end
                S_MQ: begin
                    r_cur   <= r_head[mq_rdata];
                    r_prev  <= NIL;
                    r_first <= 1'b1;
                    r_steps <= '0;
                    r_uq    <= mq_rdata;
                    r_state <= S_DONE;
                    unique case (r_cmd)
                        CMD_ENQUEUE: begin
                            if (r_queued[r_ch]) begin
                                r_status <= ST_QUEUED;
                            end else begin
                                r_state <= S_APP1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!r_queued[r_ch]) begin
                                r_status <= ST_NOT_QUEUED;
                                r_show   <= 1'b0;
                            end else begin
                                r_q     <= mq_rdata;
                                r_state <= S_WALK;
                            end
                        end
                        CMD_MOVE: begin
                            if (!r_queued[r_ch]) begin
                                r_status <= ST_NOT_QUEUED;
                            end else if (mq_rdata != r_q) begin
                                r_state <= S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_WALK: begin
                    if (l_stop) begin
                        r_cur   <= l_cur;
                        r_first <= 1'b1;
                        r_state <= S_FIX;
                    end else begin
                        r_prev  <= l_cur;
                        r_steps <= r_steps + 1'b1;
                        r_first <= 1'b0;
                    end
                end
                S_FIX: begin
                    if (r_cur == l_ch_link) begin
                        if (r_prev == NIL) begin
                            r_head[r_uq] <= nl_rdata;
                        end
                        if (r_tail[r_uq] == l_ch_link) begin
                            r_tail[r_uq] <= r_prev;
                        end
                    end
                    r_queued[r_ch] <= 1'b0;
                    r_state        <= (r_cmd == CMD_MOVE) ? S_APP1 : S_DONE;
                end
                S_APP1: begin
                    r_queued[r_ch] <= 1'b1;
                    r_state        <= S_APP2;
                end
                S_APP2: begin
                    if (r_head[r_q] == NIL) begin
                        r_head[r_q] <= l_ch_link;
                    end
                    r_tail[r_q] <= l_ch_link;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (l_out_load) begin
                        r_out_status <= r_status;
                        r_out_hv     <= l_hv;
                        r_out_hc     <= l_hv ? l_head[CHAN_W-1:0] : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.head_valid   = r_out_hv;
    assign o_rsp.head_channel = r_out_hc;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        l_accept |=> r_state == S_MQ)
        else $error("Accepted command did not start the sequencer.");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_steps <= t_steps'(NUM_CHANNELS))
        else $error("List walk exceeded the channel count.");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.head_valid |-> o_rsp.head_channel == '0)
        else $error("Empty queue reported a nonzero head channel.");

    for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_ends
        a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_head[g] == NIL) == (r_tail[g] == NIL))
            else $error("Queue head and tail disagree on emptiness.");
    end
endmodule

>>> sim/testbench.sv
// Self-checking testbench of the linked-list multi-queue manager with a model of its lists.
`timescale 1ns / 1ps
module testbench;
    import lmq_pkg::*;

    typedef struct packed {
        t_status status;
        logic    head_valid;
        t_chan   head_channel;
    } t_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lmq_cmd_if cmd_bus ();
    lmq_rsp_if rsp_bus ();

    linked_multi_queue_manager_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    t_link   link_of  [NUM_CHANNELS];
    t_queue  owner_of [NUM_CHANNELS];
    bit      linked   [NUM_CHANNELS];
    t_link   first_of [NUM_QUEUES];
    t_link   last_of  [NUM_QUEUES];
    t_result pending_results [$];
    bit      enrolled [NUM_CHANNELS];
    int      error_count = 0;
    bit      sender_pauses   = 1'b0;
    bit      receiver_pauses = 1'b0;

    always #5 clk = ~clk;

    function automatic void lists_reset();
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            link_of[i]  = NIL;
            owner_of[i] = '0;
            linked[i]   = 1'b0;
            enrolled[i] = 1'b0;
        end
        for (int i = 0; i < NUM_QUEUES; i++) begin
            first_of[i] = NIL;
            last_of[i]  = NIL;
        end
    endfunction

    function automatic void lists_append(t_chan ch, t_queue q);
        link_of[ch]  = NIL;
        owner_of[ch] = q;
        linked[ch]   = 1'b1;
        if (first_of[q] == NIL)
            first_of[q] = t_link'(ch);
        else if (last_of[q] < NIL)
            link_of[last_of[q][CHAN_W-1:0]] = t_link'(ch);
        last_of[q] = t_link'(ch);
    endfunction

    function automatic void lists_unlink(t_chan ch);
        t_queue q;
        t_link  prev;
        t_link  cur;
        int     steps;
        q     = t_queue'(owner_of[ch] % NUM_QUEUES);
        prev  = NIL;
        cur   = first_of[q];
        steps = 0;
        while (cur != t_link'(ch) && cur < NIL && steps < NUM_CHANNELS) begin
            prev = cur;
            cur  = link_of[cur[CHAN_W-1:0]];
            steps++;
        end
        if (cur == t_link'(ch)) begin
            if (prev == NIL)
                first_of[q] = link_of[ch];
            else
                link_of[prev[CHAN_W-1:0]] = link_of[ch];
            if (last_of[q] == t_link'(ch))
                last_of[q] = prev;
        end
        linked[ch]  = 1'b0;
        link_of[ch] = NIL;
    endfunction

    function automatic t_result lists_command(t_cmd_code cmd, t_chan ch, logic [1:0] q_raw);
        t_result res;
        t_queue  q;
        bit      in_range;
        bit      queued;
        bit      show;
        q          = t_queue'(q_raw % NUM_QUEUES);
        in_range   = int'(ch) < NUM_CHANNELS;
        queued     = in_range && linked[ch];
        show       = 1'b1;
        res        = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_ENQUEUE: begin
                if (!in_range)
                    res.status = ST_NOT_QUEUED;
                else if (queued)
                    res.status = ST_QUEUED;
                else
                    lists_append(ch, q);
            end
            CMD_REMOVE: begin
                if (!queued) begin
                    res.status = ST_NOT_QUEUED;
                    show       = 1'b0;
                end else begin
                    q = t_queue'(owner_of[ch] % NUM_QUEUES);
                    lists_unlink(ch);
                end
            end
            CMD_MOVE: begin
                if (!queued) begin
                    res.status = ST_NOT_QUEUED;
                end else if (t_queue'(owner_of[ch] % NUM_QUEUES) != q) begin
                    lists_unlink(ch);
                    lists_append(ch, q);
                end
            end
            default: ;
        endcase
        if (show && first_of[q] < NIL) begin
            res.head_valid   = 1'b1;
            res.head_channel = t_chan'(first_of[q]);
        end
        return res;
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // Results are checked before the command of the same edge is modeled; a result
    // never leaves in the cycle its command is accepted.
    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing expected, status %0d head %0d/%0d",
                             $time, rsp_bus.status, rsp_bus.head_valid, rsp_bus.head_channel);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", int'(want.status), int'(rsp_bus.status));
                    compare_field("head_valid", int'(want.head_valid),
                                  int'(rsp_bus.head_valid));
                    compare_field("head_channel", int'(want.head_channel),
                                  int'(rsp_bus.head_channel));
                end
            end
            if (cmd_bus.valid && cmd_bus.ready)
                pending_results.push_back(lists_command(cmd_bus.command, cmd_bus.channel,
                                                        cmd_bus.queue));
        end
    end

    initial begin : result_sink
        int stall;
        rsp_bus.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = receiver_pauses ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
        end
    end

    task automatic send_command(t_cmd_code cmd, t_chan ch, logic [1:0] q);
        int gap;
        gap = sender_pauses ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= cmd;
        cmd_bus.channel <= ch;
        cmd_bus.queue   <= q;
        do @(posedge clk); while (!cmd_bus.ready);
        if (cmd == CMD_ENQUEUE)
            enrolled[ch] = 1'b1;
        else if (cmd == CMD_REMOVE)
            enrolled[ch] = 1'b0;
    endtask

    task automatic test_directed();
        sender_pauses   = 1'b1;
        receiver_pauses = 1'b1;
        send_command(CMD_HEAD, 6'd0, 2'd0);
        send_command(CMD_REMOVE, 6'd5, 2'd2);
        send_command(CMD_MOVE, 6'd5, 2'd1);
        send_command(CMD_ENQUEUE, 6'd0, 2'd0);
        send_command(CMD_ENQUEUE, 6'd63, 2'd3);
        send_command(CMD_ENQUEUE, 6'd0, 2'd1);
        send_command(CMD_ENQUEUE, 6'd10, 2'd0);
        send_command(CMD_ENQUEUE, 6'd20, 2'd0);
        send_command(CMD_ENQUEUE, 6'd30, 2'd0);
        send_command(CMD_REMOVE, 6'd20, 2'd3);
        send_command(CMD_REMOVE, 6'd30, 2'd1);
        send_command(CMD_REMOVE, 6'd0, 2'd2);
        send_command(CMD_REMOVE, 6'd10, 2'd0);
        send_command(CMD_MOVE, 6'd63, 2'd3);
        send_command(CMD_MOVE, 6'd63, 2'd2);
        send_command(CMD_HEAD, 6'd63, 2'd3);
        send_command(CMD_HEAD, 6'd0, 2'd2);
        send_command(CMD_ENQUEUE, 6'd42, 2'd2);
        send_command(CMD_MOVE, 6'd63, 2'd0);
        send_command(CMD_ENQUEUE, 6'd21, 2'd1);
        send_command(CMD_MOVE, 6'd42, 2'd1);
        send_command(CMD_HEAD, 6'd0, 2'd1);
    endtask

    // Every channel goes into one queue so that removal walks the longest list.
    task automatic test_long_walk();
        int         order [NUM_CHANNELS];
        int         j;
        int         tmp;
        logic [1:0] lane;
        sender_pauses   = 1'b0;
        receiver_pauses = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (enrolled[c])
                send_command(CMD_REMOVE, t_chan'(c), 2'd0);
            order[c] = c;
        end
        for (int i = NUM_CHANNELS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        lane = 2'($urandom_range(0, 3));
        for (int i = 0; i < NUM_CHANNELS; i++)
            send_command(CMD_ENQUEUE, t_chan'(order[i]), lane);
        send_command(CMD_REMOVE, t_chan'(order[NUM_CHANNELS - 1]), lane);
        send_command(CMD_MOVE, t_chan'(order[NUM_CHANNELS - 2]), lane + 2'd1);
        send_command(CMD_REMOVE, t_chan'(order[NUM_CHANNELS / 2]), lane);
        send_command(CMD_HEAD, t_chan'(order[0]), lane);
        send_command(CMD_REMOVE, t_chan'(order[0]), lane);
        send_command(CMD_HEAD, t_chan'(order[1]), lane);
    endtask

    // Mostly commands that find the channel in the expected state, with some that fail.
    task automatic test_random(int count);
        t_cmd_code cmd;
        t_chan     ch;
        bit        want_enrolled;
        int        pick;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                sender_pauses   = $urandom_range(0, 3) != 0;
                receiver_pauses = $urandom_range(0, 3) != 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                cmd = CMD_ENQUEUE;
            else if (pick < 60)
                cmd = CMD_REMOVE;
            else if (pick < 85)
                cmd = CMD_MOVE;
            else
                cmd = CMD_HEAD;
            ch            = t_chan'($urandom_range(0, NUM_CHANNELS - 1));
            want_enrolled = cmd != CMD_ENQUEUE;
            if (cmd != CMD_HEAD && $urandom_range(0, 9) != 0)
                for (int tries = 0; tries < 16 && enrolled[ch] != want_enrolled; tries++)
                    ch = t_chan'($urandom_range(0, NUM_CHANNELS - 1));
            send_command(cmd, ch, 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (NUM_CHANNELS + 16) @(posedge clk);
    endtask

    initial begin
        cmd_bus.valid   <= 1'b0;
        cmd_bus.command <= CMD_HEAD;
        cmd_bus.channel <= '0;
        cmd_bus.queue   <= '0;
        lists_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_walk();
        test_random(355);
        drain();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lmq_pkg.sv
rtl/core/lmq_cmd_if.sv
rtl/core/lmq_rsp_if.sv
rtl/core/lmq_ram.sv
rtl/core/linked_multi_queue_manager_unit.sv
sim/testbench.sv
